// ----- hw/rtl/cial_pkg.sv -----
// Package for the complex integer ALU: operation codes and the
// classification struct passed from the front end to the execution back end.
// No dependencies.
`timescale 1ns / 1ps

package cial_pkg;

  localparam int OP_W = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_MAG = 3'd4;

  // Classification of one transaction, fixed at the front end
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            div_zero;  // divisor is 0 + 0i
  } cls_t;

  localparam int CLS_W = $bits(cls_t);

endpackage

// ----- hw/rtl/cial_front.sv -----
// Front end of the complex integer ALU: takes input transactions, classifies
// them and forms all operand products for the queue.
// Depends on cial_pkg.
`timescale 1ns / 1ps

module cial_front #(
  parameter int OW = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [cial_pkg::OP_W-1:0] operation,
  input  logic signed [OW-1:0]      a_real,
  input  logic signed [OW-1:0]      a_imag,
  input  logic signed [OW-1:0]      b_real,
  input  logic signed [OW-1:0]      b_imag,
  output logic                      push,
  input  logic                      full,
  output cial_pkg::cls_t            cls,
  output logic signed [OW-1:0]      ar,
  output logic signed [OW-1:0]      ai,
  output logic signed [OW-1:0]      br,
  output logic signed [OW-1:0]      bi,
  output logic signed [2*OW-1:0]    p_rr,
  output logic signed [2*OW-1:0]    p_ii,
  output logic signed [2*OW-1:0]    p_ir,
  output logic signed [2*OW-1:0]    p_ri,
  output logic signed [2*OW-1:0]    p_bb_r,
  output logic signed [2*OW-1:0]    p_bb_i,
  output logic signed [2*OW-1:0]    p_aa_r,
  output logic signed [2*OW-1:0]    p_aa_i
);
  import cial_pkg::*;

  logic v;
  logic accept;

  // Stall only while holding a transaction the queue cannot take
  assign in_stall = v && full;
  assign accept   = in_valid && !in_stall;
  assign push     = v && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (accept) begin
      v <= 1'b1;
    end else if (push) begin
      v <= 1'b0;
    end
  end

  // Input register and classification
  always_ff @(posedge clk) begin
    if (accept) begin
      cls.op       <= operation;
      cls.div_zero <= (b_real == '0) && (b_imag == '0);
      ar           <= a_real;
      ai           <= a_imag;
      br           <= b_real;
      bi           <= b_imag;
    end
  end

  // Operand products, registered by the queue
  assign p_rr   = ar * br;
  assign p_ii   = ai * bi;
  assign p_ir   = ai * br;
  assign p_ri   = ar * bi;
  assign p_bb_r = br * br;
  assign p_bb_i = bi * bi;
  assign p_aa_r = ar * ar;
  assign p_aa_i = ai * ai;

endmodule

// ----- hw/rtl/cial_queue.sv -----
// Short FIFO between the front end and the back end of the complex ALU.
// Holds packed classified transactions. Depends on nothing beyond itself.
`timescale 1ns / 1ps

module cial_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/cial_back.sv -----
// Back end of the complex ALU: add/sub/mul direct path, a pipelined restoring
// divider (one quotient bit per stage) and a pipelined integer square root
// (one root bit per stage), all in one stall-together pipeline. Uses cial_pkg.
`timescale 1ns / 1ps

module cial_back #(
  parameter int OW = 16,
  parameter int FB = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  output logic                        pop,
  input  cial_pkg::cls_t              cls,
  input  logic signed [OW-1:0]        ar,
  input  logic signed [OW-1:0]        ai,
  input  logic signed [OW-1:0]        br,
  input  logic signed [OW-1:0]        bi,
  input  logic signed [2*OW-1:0]      p_rr,
  input  logic signed [2*OW-1:0]      p_ii,
  input  logic signed [2*OW-1:0]      p_ir,
  input  logic signed [2*OW-1:0]      p_ri,
  input  logic signed [2*OW-1:0]      p_bb_r,
  input  logic signed [2*OW-1:0]      p_bb_i,
  input  logic signed [2*OW-1:0]      p_aa_r,
  input  logic signed [2*OW-1:0]      p_aa_i,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [2*OW+FB:0]     result_real,
  output logic signed [2*OW+FB:0]     result_imag,
  output logic                        status
);
  import cial_pkg::*;

  localparam int PW     = 2 * OW;
  localparam int SW     = PW + 1;
  localparam int RES_W  = SW + FB;
  localparam int NUM_W  = PW + FB;
  localparam int DEN_W  = PW;
  localparam int ROOT_W = OW + FB;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int DEPTH  = NUM_W;

  logic en;

  // Whole pipeline moves unless a finished result is held
  assign en  = !out_valid || !out_stall;
  assign pop = en && head_valid;

  // ---------------- entry stage ----------------
  logic signed [RES_W-1:0] dir_re_c;
  logic signed [RES_W-1:0] dir_im_c;
  logic signed [SW-1:0]    n_re;
  logic signed [SW-1:0]    n_im;
  logic [SW-1:0]           n_re_abs;
  logic [SW-1:0]           n_im_abs;
  logic [DEN_W-1:0]        den_c;
  logic [PW-1:0]           sq_c;

  always_comb begin
    dir_re_c = '0;
    dir_im_c = '0;
    case (cls.op)
      OP_ADD: begin
        dir_re_c = (RES_W'(ar) + RES_W'(br)) <<< FB;
        dir_im_c = (RES_W'(ai) + RES_W'(bi)) <<< FB;
      end
      OP_SUB: begin
        dir_re_c = (RES_W'(ar) - RES_W'(br)) <<< FB;
        dir_im_c = (RES_W'(ai) - RES_W'(bi)) <<< FB;
      end
      OP_MUL: begin
        dir_re_c = (RES_W'(p_rr) - RES_W'(p_ii)) <<< FB;
        dir_im_c = (RES_W'(p_ir) + RES_W'(p_ri)) <<< FB;
      end
      default: begin
        dir_re_c = '0;
        dir_im_c = '0;
      end
    endcase
  end

  // Divider operands: sign and magnitude of numerators, squared divisor norm
  assign n_re     = SW'(p_rr) + SW'(p_ii);
  assign n_im     = SW'(p_ir) - SW'(p_ri);
  assign n_re_abs = n_re[SW-1] ? $unsigned(-n_re) : $unsigned(n_re);
  assign n_im_abs = n_im[SW-1] ? $unsigned(-n_im) : $unsigned(n_im);
  assign den_c    = $unsigned(p_bb_r) + $unsigned(p_bb_i);
  assign sq_c     = $unsigned(p_aa_r) + $unsigned(p_aa_i);

  // ---------------- pipeline registers ----------------
  logic                    vld    [0:DEPTH];
  cls_t                    scls   [0:DEPTH];
  logic signed [RES_W-1:0] dir_re [0:DEPTH];
  logic signed [RES_W-1:0] dir_im [0:DEPTH];
  logic                    neg_re [0:DEPTH];
  logic                    neg_im [0:DEPTH];
  logic [NUM_W-1:0]        dq_re  [0:DEPTH];
  logic [NUM_W-1:0]        dq_im  [0:DEPTH];
  logic [DEN_W-1:0]        rem_re [0:DEPTH];
  logic [DEN_W-1:0]        rem_im [0:DEPTH];
  logic [DEN_W-1:0]        den    [0:DEPTH];
  logic [RAD_W-1:0]        rad    [0:DEPTH];
  logic [ROOT_W:0]         srem   [0:DEPTH];
  logic [ROOT_W-1:0]       root   [0:DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      scls[0]   <= cls;
      dir_re[0] <= dir_re_c;
      dir_im[0] <= dir_im_c;
      neg_re[0] <= n_re[SW-1];
      neg_im[0] <= n_im[SW-1];
      dq_re[0]  <= NUM_W'(n_re_abs[PW-1:0]) << FB;
      dq_im[0]  <= NUM_W'(n_im_abs[PW-1:0]) << FB;
      rem_re[0] <= '0;
      rem_im[0] <= '0;
      den[0]    <= den_c;
      rad[0]    <= RAD_W'(sq_c) << (2 * FB);
      srem[0]   <= '0;
      root[0]   <= '0;
    end
  end

  // ---------------- iteration stages ----------------
  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    logic [DEN_W:0]    dsh_re;
    logic [DEN_W:0]    dsh_im;
    logic [DEN_W:0]    dif_re;
    logic [DEN_W:0]    dif_im;
    logic              ge_re;
    logic              ge_im;

    // One restoring-division step for each of the two quotients
    assign dsh_re = {rem_re[k], dq_re[k][NUM_W-1]};
    assign dsh_im = {rem_im[k], dq_im[k][NUM_W-1]};
    assign dif_re = dsh_re - {1'b0, den[k]};
    assign dif_im = dsh_im - {1'b0, den[k]};
    assign ge_re  = dsh_re >= {1'b0, den[k]};
    assign ge_im  = dsh_im >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        scls[k+1]   <= scls[k];
        dir_re[k+1] <= dir_re[k];
        dir_im[k+1] <= dir_im[k];
        neg_re[k+1] <= neg_re[k];
        neg_im[k+1] <= neg_im[k];
        den[k+1]    <= den[k];
        rem_re[k+1] <= ge_re ? dif_re[DEN_W-1:0] : dsh_re[DEN_W-1:0];
        rem_im[k+1] <= ge_im ? dif_im[DEN_W-1:0] : dsh_im[DEN_W-1:0];
        dq_re[k+1]  <= {dq_re[k][NUM_W-2:0], ge_re};
        dq_im[k+1]  <= {dq_im[k][NUM_W-2:0], ge_im};
      end
    end

    if (k < ROOT_W) begin : g_sqrt
      logic [ROOT_W+2:0] ssh;
      logic [ROOT_W+2:0] trial;
      logic [ROOT_W+2:0] sdif;
      logic              sge;

      // One root bit per stage: bring down two radicand bits, try 4r+1
      assign ssh   = {srem[k], rad[k][RAD_W-1 -: 2]};
      assign trial = (ROOT_W+3)'({root[k], 2'b01});
      assign sdif  = ssh - trial;
      assign sge   = ssh >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rad[k+1]  <= rad[k] << 2;
          srem[k+1] <= sge ? sdif[ROOT_W:0] : ssh[ROOT_W:0];
          root[k+1] <= {root[k][ROOT_W-2:0], sge};
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          rad[k+1]  <= rad[k];
          srem[k+1] <= srem[k];
          root[k+1] <= root[k];
        end
      end
    end
  end

  // ---------------- result select and output register ----------------
  logic signed [RES_W-1:0] q_re;
  logic signed [RES_W-1:0] q_im;
  logic signed [RES_W-1:0] fin_re;
  logic signed [RES_W-1:0] fin_im;
  logic                    fin_st;

  assign q_re = neg_re[DEPTH] ? -$signed(RES_W'(dq_re[DEPTH]))
                              : $signed(RES_W'(dq_re[DEPTH]));
  assign q_im = neg_im[DEPTH] ? -$signed(RES_W'(dq_im[DEPTH]))
                              : $signed(RES_W'(dq_im[DEPTH]));

  always_comb begin
    fin_re = dir_re[DEPTH];
    fin_im = dir_im[DEPTH];
    fin_st = 1'b0;
    case (scls[DEPTH].op)
      OP_DIV: begin
        fin_st = scls[DEPTH].div_zero;
        fin_re = scls[DEPTH].div_zero ? '0 : q_re;
        fin_im = scls[DEPTH].div_zero ? '0 : q_im;
      end
      OP_MAG: begin
        fin_re = $signed(RES_W'(root[DEPTH]));
        fin_im = '0;
      end
      default: begin
        fin_re = dir_re[DEPTH];
        fin_im = dir_im[DEPTH];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[DEPTH]) begin
      result_real <= fin_re;
      result_imag <= fin_im;
      status      <= fin_st;
    end
  end

  // ---------------- checks ----------------
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (result_real == '0) && (result_imag == '0))
    else $error("divide error result not zero");

  a_last_moves: assert property (@(posedge clk) disable iff (rst)
    en && vld[DEPTH] |=> out_valid)
    else $error("last stage transaction lost");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("held result dropped");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld[1]))
    else $error("pipeline moved while frozen");

endmodule

// ----- hw/rtl/complex_integer_alu_unit.sv -----
// The delay from input acceptance to result valid is set mainly by the divider
// pipeline, which resolves one quotient bit per stage. Throughput: one
// transaction per cycle while out_stall is low.
// Reset (synchronous, active high) empties the input register, queue and
// pipeline; datapath registers are not cleared.
// Depends on cial_pkg, cial_front, cial_queue, cial_back.
`timescale 1ns / 1ps

module complex_integer_alu_unit #(
  parameter int OPERAND_WIDTH = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  logic [cial_pkg::OP_W-1:0]                     operation,
  input  logic signed [OPERAND_WIDTH-1:0]               a_real,
  input  logic signed [OPERAND_WIDTH-1:0]               a_imag,
  input  logic signed [OPERAND_WIDTH-1:0]               b_real,
  input  logic signed [OPERAND_WIDTH-1:0]               b_imag,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic signed [2*OPERAND_WIDTH+FRACTION_BITS:0] result_real,
  output logic signed [2*OPERAND_WIDTH+FRACTION_BITS:0] result_imag,
  output logic                                          status
);
  import cial_pkg::*;

  localparam int OW  = OPERAND_WIDTH;
  localparam int PW  = 2 * OW;
  localparam int E_W = CLS_W + 4 * OW + 8 * PW;

  logic push;
  logic full;
  logic pop;
  logic empty;

  cls_t                 f_cls;
  logic signed [OW-1:0] f_ar, f_ai, f_br, f_bi;
  logic signed [PW-1:0] f_rr, f_ii, f_ir, f_ri, f_bbr, f_bbi, f_aar, f_aai;

  cls_t                 h_cls;
  logic signed [OW-1:0] h_ar, h_ai, h_br, h_bi;
  logic signed [PW-1:0] h_rr, h_ii, h_ir, h_ri, h_bbr, h_bbi, h_aar, h_aai;

  logic [E_W-1:0] wdata;
  logic [E_W-1:0] rdata;

  // Front end: input register, classification, products
  cial_front #(.OW(OW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .operation(operation),
    .a_real   (a_real),
    .a_imag   (a_imag),
    .b_real   (b_real),
    .b_imag   (b_imag),
    .push     (push),
    .full     (full),
    .cls      (f_cls),
    .ar       (f_ar),
    .ai       (f_ai),
    .br       (f_br),
    .bi       (f_bi),
    .p_rr     (f_rr),
    .p_ii     (f_ii),
    .p_ir     (f_ir),
    .p_ri     (f_ri),
    .p_bb_r   (f_bbr),
    .p_bb_i   (f_bbi),
    .p_aa_r   (f_aar),
    .p_aa_i   (f_aai)
  );

  assign wdata = {f_cls, f_ar, f_ai, f_br, f_bi,
                  f_rr, f_ii, f_ir, f_ri, f_bbr, f_bbi, f_aar, f_aai};

  // Decoupling queue
  cial_queue #(.WIDTH(E_W)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(wdata),
    .full (full),
    .pop  (pop),
    .rdata(rdata),
    .empty(empty)
  );

  assign {h_cls, h_ar, h_ai, h_br, h_bi,
          h_rr, h_ii, h_ir, h_ri, h_bbr, h_bbi, h_aar, h_aai} = rdata;

  // Back end: arithmetic, divider and square root pipeline
  cial_back #(.OW(OW), .FB(FRACTION_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!empty),
    .pop        (pop),
    .cls        (h_cls),
    .ar         (h_ar),
    .ai         (h_ai),
    .br         (h_br),
    .bi         (h_bi),
    .p_rr       (h_rr),
    .p_ii       (h_ii),
    .p_ir       (h_ir),
    .p_ri       (h_ri),
    .p_bb_r     (h_bbr),
    .p_bb_i     (h_bbi),
    .p_aa_r     (h_aar),
    .p_aa_i     (h_aai),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_real(result_real),
    .result_imag(result_imag),
    .status     (status)
  );

endmodule
